// ===== rtl/vpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vpc_pkg;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned CUBE_SIDE     = 3;
  localparam int unsigned TRIPLES       = CUBE_SIDE * CUBE_SIDE;
  localparam int unsigned PIXELS        = 3 * TRIPLES;
  localparam int unsigned PAT_DEPTH     = TABLE_ENTRIES * TRIPLES;
  localparam int unsigned PAT_AW        = $clog2(PAT_DEPTH);
  localparam int unsigned ENTRY_W       = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned EIDX_W        = $clog2(TABLE_ENTRIES);
  localparam int unsigned TPOS_W        = (TRIPLES > 1) ? $clog2(TRIPLES) : 1;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned TRIP_W  = 3 * PIX_W;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned CNT_DW  = COUNT_W + 1;
  localparam int unsigned SEL_W   = 5;
  localparam int unsigned OIDX_W  = 8;
  localparam int unsigned MINC_W  = 16;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [MINC_W-1:0]  MIN_COUNT_RESET = 16'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
  localparam logic [PADDR_W-1:0] ADDR_MIN_COUNT  = 3'd0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRD,
    S_SCMP,
    S_INS,
    S_HRD,
    S_HINC,
    S_FRD,
    S_OUT
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic take;
    logic rd_pat;
    logic rd_final;
    logic step_t;
    logic next_entry;
    logic wr_ins;
    logic rd_cnt;
    logic wr_inc;
    logic set_drop;
    logic set_hit;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic action;
    logic last_triple;
    logic used_zero;
    logic full;
    logic match;
    logic t_last;
    logic e_last;
    logic out_free;
  } dp_stat_t;

  // k / 3 for k below 32
  function automatic logic [SEL_W-1:0] div3(input logic [SEL_W-1:0] k);
    logic [12:0] prod;
    prod = 13'(k) * 13'd86;
    return prod[12:8];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/vpc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface vpc_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] pix_first;
  logic [7:0] pix_middle;
  logic [7:0] pix_last;
  logic [7:0] entry_sel;
  logic [4:0] element_sel;

  modport source (output valid, action, pix_first, pix_middle, pix_last, entry_sel,
                  element_sel, input ready);
  modport sink (input valid, action, pix_first, pix_middle, pix_last, entry_sel,
                element_sel, output ready);
endinterface

interface vpc_out_if;
  logic        valid;
  logic        ready;
  logic        is_readout;
  logic        hit;
  logic        dropped;
  logic [7:0]  entry_index;
  logic [31:0] count;
  logic        entry_valid;
  logic        qualifies;
  logic [7:0]  element_value;

  modport source (output valid, is_readout, hit, dropped, entry_index, count, entry_valid,
                  qualifies, element_value, input ready);
  modport sink (input valid, is_readout, hit, dropped, entry_index, count, entry_valid,
                qualifies, element_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/voxel_pattern_counter_top.sv =====
// Channel   Dir  Word
// in_i      in   action, pix_first, pix_middle, pix_last, entry_sel, element_sel
// out_o     out  is_readout, hit, dropped, entry_index, count, entry_valid,
//                qualifies, element_value
// apb       in   min_count at 0x0
//
// A push that does not finish a pattern is taken in S_IDLE; a readout goes through S_FRD to S_OUT.
// A finished pattern is compared stored triple by stored triple (S_SRD pattern-RAM read,
// S_SCMP compare), then gets a hit update (S_HRD, S_HINC), an insert (S_INS) or a drop.
// Result sits in an output register; the next word is taken while it waits, and a
// result that finds the register still full holds the controller until it drains.
// Reset clears the fill count and sets min_count to 10; table contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module voxel_pattern_counter_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [vpc_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [vpc_pkg::PDATA_W-1:0]   pwdata,
  output logic      [vpc_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  vpc_in_if.sink                             in_i,
  vpc_out_if.source                          out_o
);
  import vpc_pkg::*;

  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic              cfg_we;
  logic [MINC_W-1:0] min_count;

  assign pready     = 1'b1;
  assign cfg_we     = psel & penable & pwrite & (paddr == ADDR_MIN_COUNT);
  assign prdata     = (paddr == ADDR_MIN_COUNT) ? PDATA_W'(min_count) : '0;
  assign in_i.ready = cmd.in_ready;

  vpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vpc_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .action_i        (in_i.action),
    .pix_first_i     (in_i.pix_first),
    .pix_middle_i    (in_i.pix_middle),
    .pix_last_i      (in_i.pix_last),
    .entry_sel_i     (in_i.entry_sel),
    .element_sel_i   (in_i.element_sel),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (pwdata[MINC_W-1:0]),
    .min_count_o     (min_count),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .is_readout_o    (out_o.is_readout),
    .hit_o           (out_o.hit),
    .dropped_o       (out_o.dropped),
    .entry_index_o   (out_o.entry_index),
    .count_o         (out_o.count),
    .entry_valid_o   (out_o.entry_valid),
    .qualifies_o     (out_o.qualifies),
    .element_value_o (out_o.element_value)
  );
endmodule
`default_nettype wire

// ===== rtl/vpc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/vpc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vpc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire vpc_pkg::dp_stat_t  stat_i,
  output vpc_pkg::ctrl_cmd_t      cmd_o
);
  import vpc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.action) begin
            state_d = S_FRD;
          end else if (stat_i.last_triple) begin
            state_d = stat_i.used_zero ? S_INS : S_SRD;
          end
        end
      end
      S_SRD: state_d = S_SCMP;
      S_SCMP: begin
        if (stat_i.match) begin
          state_d = stat_i.t_last ? S_HRD : S_SRD;
        end else if (stat_i.e_last) begin
          state_d = stat_i.full ? S_OUT : S_INS;
        end else begin
          state_d = S_SRD;
        end
      end
      S_INS: begin
        if (stat_i.t_last) begin
          state_d = S_FRD;
        end
      end
      S_HRD:  state_d = S_HINC;
      S_HINC: state_d = S_FRD;
      S_FRD:  state_d = S_OUT;
      S_OUT: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.take     = in_valid_i;
      end
      S_SRD: cmd_o.rd_pat = 1'b1;
      S_SCMP: begin
        if (stat_i.match) begin
          cmd_o.set_hit = stat_i.t_last;
          cmd_o.step_t  = !stat_i.t_last;
        end else begin
          cmd_o.next_entry = 1'b1;
          cmd_o.set_drop   = stat_i.e_last & stat_i.full;
        end
      end
      S_INS: begin
        cmd_o.wr_ins = 1'b1;
        cmd_o.step_t = !stat_i.t_last;
      end
      S_HRD:  cmd_o.rd_cnt   = 1'b1;
      S_HINC: cmd_o.wr_inc   = 1'b1;
      S_FRD:  cmd_o.rd_final = 1'b1;
      S_OUT:  cmd_o.load_out = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/vpc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vpc_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire vpc_pkg::ctrl_cmd_t            cmd_i,
  output vpc_pkg::dp_stat_t                  stat_o,
  input  wire logic                          action_i,
  input  wire logic [7:0]                    pix_first_i,
  input  wire logic [7:0]                    pix_middle_i,
  input  wire logic [7:0]                    pix_last_i,
  input  wire logic [7:0]                    entry_sel_i,
  input  wire logic [4:0]                    element_sel_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [vpc_pkg::MINC_W-1:0]    cfg_wdata_i,
  output logic      [vpc_pkg::MINC_W-1:0]    min_count_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic                               is_readout_o,
  output logic                               hit_o,
  output logic                               dropped_o,
  output logic      [7:0]                    entry_index_o,
  output logic      [31:0]                   count_o,
  output logic                               entry_valid_o,
  output logic                               qualifies_o,
  output logic      [7:0]                    element_value_o
);
  import vpc_pkg::*;

  logic [MINC_W-1:0]  min_count_q;
  logic [ENTRY_W-1:0] used_q;
  logic [TPOS_W-1:0]  pos_q;
  logic [TRIP_W-1:0]  buf_q [TRIPLES];
  logic [PIX_W-1:0]   first_q;
  logic               eq_q;
  logic [ENTRY_W-1:0] e_q;
  logic [PAT_AW-1:0]  base_q;
  logic [TPOS_W-1:0]  t_q;
  logic [SEL_W-1:0]   sel_q;
  logic               ro_q, hit_q, drop_q, valid_q;
  logic               out_valid_q;

  logic [TRIP_W-1:0]  pat_rdata;
  logic [CNT_DW-1:0]  cnt_rdata;
  logic [PAT_AW-1:0]  walk_addr, final_addr, pat_raddr;
  logic [SEL_W-1:0]   tsel;
  logic [1:0]         comp;
  logic               in_range;
  logic [COUNT_W-1:0] cnt_inc;
  logic               cnt_we;
  logic [CNT_DW-1:0]  cnt_wdata;
  logic [TRIP_W-1:0]  triple;
  logic               trip_eq;
  logic [PIX_W-1:0]   elem;

  assign triple    = {pix_first_i, pix_middle_i, pix_last_i};
  assign walk_addr = base_q + PAT_AW'(t_q);
  assign tsel      = div3(sel_q);
  assign comp      = 2'(sel_q - SEL_W'(3 * tsel));
  assign in_range  = 32'(sel_q) < PIXELS;
  assign final_addr = base_q + (in_range ? PAT_AW'(tsel) : '0);
  assign pat_raddr = cmd_i.rd_final ? final_addr : walk_addr;
  assign cnt_inc   = (cnt_rdata[COUNT_W-1:0] == COUNT_MAX) ? COUNT_MAX
                     : cnt_rdata[COUNT_W-1:0] + 1'b1;
  assign cnt_we    = cmd_i.wr_inc | (cmd_i.wr_ins & stat_o.t_last);
  assign cnt_wdata = cmd_i.wr_inc ? {cnt_rdata[COUNT_W], cnt_inc}
                     : {eq_q, COUNT_W'(1)};
  assign trip_eq   = (pos_q == '0)
                     ? (pix_middle_i == pix_first_i) && (pix_last_i == pix_first_i)
                     : eq_q && (pix_first_i == first_q) && (pix_middle_i == first_q)
                       && (pix_last_i == first_q);

  vpc_ram #(.WIDTH(TRIP_W), .DEPTH(PAT_DEPTH)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_ins),
    .waddr_i (walk_addr),
    .wdata_i (buf_q[t_q]),
    .re_i    (cmd_i.rd_pat | cmd_i.rd_final),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  vpc_ram #(.WIDTH(CNT_DW), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (e_q[EIDX_W-1:0]),
    .wdata_i (cnt_wdata),
    .re_i    (cmd_i.rd_cnt | cmd_i.rd_final),
    .raddr_i (e_q[EIDX_W-1:0]),
    .rdata_o (cnt_rdata)
  );

  always_comb begin
    stat_o.action      = action_i;
    stat_o.last_triple = 32'(pos_q) == TRIPLES - 1;
    stat_o.used_zero   = used_q == '0;
    stat_o.full        = 32'(used_q) == TABLE_ENTRIES;
    stat_o.match       = pat_rdata == buf_q[t_q];
    stat_o.t_last      = 32'(t_q) == TRIPLES - 1;
    stat_o.e_last      = (e_q + 1'b1) == used_q;
    stat_o.out_free    = !out_valid_q | out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_count_q <= MIN_COUNT_RESET;
      used_q      <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_count_q <= cfg_wdata_i;
      end
      if (cmd_i.take && !action_i) begin
        pos_q <= stat_o.last_triple ? '0 : pos_q + 1'b1;
      end
      if (cmd_i.wr_ins && stat_o.t_last) begin
        used_q <= used_q + 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      sel_q <= element_sel_i;
      if (action_i) begin
        e_q     <= ENTRY_W'(entry_sel_i);
        base_q  <= PAT_AW'(32'(entry_sel_i) * TRIPLES);
        ro_q    <= 1'b1;
        hit_q   <= 1'b0;
        drop_q  <= 1'b0;
        valid_q <= 32'(entry_sel_i) < 32'(used_q);
      end else begin
        buf_q[pos_q] <= triple;
        eq_q         <= trip_eq;
        if (pos_q == '0) begin
          first_q <= pix_first_i;
        end
        e_q     <= '0;
        base_q  <= '0;
        t_q     <= '0;
        ro_q    <= 1'b0;
        hit_q   <= 1'b0;
        drop_q  <= 1'b0;
        valid_q <= 1'b0;
      end
    end
    if (cmd_i.step_t) begin
      t_q <= t_q + 1'b1;
    end
    if (cmd_i.next_entry) begin
      e_q    <= e_q + 1'b1;
      base_q <= base_q + PAT_AW'(TRIPLES);
      t_q    <= '0;
    end
    if (cmd_i.wr_ins && stat_o.t_last) begin
      valid_q <= 1'b1;
    end
    if (cmd_i.set_hit) begin
      hit_q   <= 1'b1;
      valid_q <= 1'b1;
    end
    if (cmd_i.set_drop) begin
      drop_q <= 1'b1;
    end
    if (cmd_i.load_out) begin
      is_readout_o    <= ro_q;
      hit_o           <= hit_q;
      dropped_o       <= drop_q;
      entry_valid_o   <= valid_q;
      entry_index_o   <= valid_q ? OIDX_W'(e_q) : '0;
      count_o         <= valid_q ? cnt_rdata[COUNT_W-1:0] : '0;
      qualifies_o     <= valid_q && !cnt_rdata[COUNT_W]
                         && (cnt_rdata[COUNT_W-1:0] > COUNT_W'(min_count_q));
      element_value_o <= (valid_q && in_range) ? elem : '0;
    end
  end

  always_comb begin
    unique case (comp)
      2'd0:    elem = pat_rdata[3*PIX_W-1:2*PIX_W];
      2'd1:    elem = pat_rdata[2*PIX_W-1:PIX_W];
      default: elem = pat_rdata[PIX_W-1:0];
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign min_count_o = min_count_q;
endmodule
`default_nettype wire

// ===== rtl/vpc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vpc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        is_readout_i,
  input wire logic        hit_i,
  input wire logic        dropped_i,
  input wire logic        entry_valid_i,
  input wire logic        qualifies_i,
  input wire logic [31:0] count_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word withdrawn while stalled");

  a_readout_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_readout_i |-> !hit_i && !dropped_i)
    else $error("readout word carries hit or dropped");

  a_drop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && dropped_i |-> !hit_i && !entry_valid_i && count_i == 32'd0)
    else $error("dropped word not cleared");

  a_hit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (hit_i || qualifies_i) |-> entry_valid_i && count_i != 32'd0)
    else $error("hit or qualifying word without a counted entry");
endmodule

bind voxel_pattern_counter_top vpc_checker u_vpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .is_readout_i  (out_o.is_readout),
  .hit_i         (out_o.hit),
  .dropped_i     (out_o.dropped),
  .entry_valid_i (out_o.entry_valid),
  .qualifies_i   (out_o.qualifies),
  .count_i       (out_o.count)
);
`default_nettype wire

// ===== tb/voxel_pattern_counter_top_tb.sv =====
`timescale 1ns / 1ps
module voxel_pattern_counter_top_tb;
  import vpc_pkg::*;

  typedef struct packed {
    logic       action;
    logic [7:0] pix_first;
    logic [7:0] pix_middle;
    logic [7:0] pix_last;
    logic [7:0] entry_sel;
    logic [4:0] element_sel;
  } in_word_t;

  typedef struct packed {
    logic        is_readout;
    logic        hit;
    logic        dropped;
    logic [7:0]  entry_index;
    logic [31:0] count;
    logic        entry_valid;
    logic        qualifies;
    logic [7:0]  element_value;
  } out_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  vpc_in_if  in_ch ();
  vpc_out_if out_ch ();

  voxel_pattern_counter_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [23:0] pat_mem [TABLE_ENTRIES][TRIPLES];
  logic [31:0] cnt_mem [TABLE_ENTRIES];
  int unsigned n_used;
  logic [23:0] gather [TRIPLES];
  int unsigned gather_pos;
  logic [15:0] thresh;

  in_word_t  pending_q [$];
  out_word_t result_q [$];
  int send_idle_pct, recv_idle_pct;
  bit hold_off;
  int n_err, n_words, n_results, n_hits, n_drops, n_reads;

  function automatic logic [7:0] pixel_at(int e, int k);
    logic [23:0] t;
    if (k >= PIXELS) return 8'd0;
    t = pat_mem[e][k / 3];
    return t[23 - 8 * (k % 3) -: 8];
  endfunction

  function automatic void fill_report(ref out_word_t r, input int e, input int k);
    logic eq;
    eq = 1'b1;
    for (int j = 1; j < PIXELS; j++) if (pixel_at(e, j) != pixel_at(e, 0)) eq = 1'b0;
    r.entry_index = e[7:0];
    r.count = cnt_mem[e];
    r.entry_valid = 1'b1;
    r.qualifies = (cnt_mem[e] > {16'd0, thresh}) && !eq;
    r.element_value = pixel_at(e, k);
  endfunction

  task automatic predict_word(input in_word_t w);
    out_word_t r;
    int found;
    logic same;
    r = '0;
    if (w.action) begin
      r.is_readout = 1'b1;
      if (w.entry_sel < n_used) fill_report(r, w.entry_sel, w.element_sel);
      result_q = {result_q, r};
      return;
    end
    gather[gather_pos] = {w.pix_first, w.pix_middle, w.pix_last};
    gather_pos++;
    if (gather_pos < TRIPLES) return;
    gather_pos = 0;
    found = -1;
    for (int e = 0; e < n_used && found < 0; e++) begin
      same = 1'b1;
      for (int t = 0; t < TRIPLES; t++) if (pat_mem[e][t] != gather[t]) same = 1'b0;
      if (same) found = e;
    end
    if (found >= 0) begin
      if (cnt_mem[found] != COUNT_MAX) cnt_mem[found]++;
      r.hit = 1'b1;
      fill_report(r, found, w.element_sel);
    end else if (n_used >= TABLE_ENTRIES) begin
      r.dropped = 1'b1;
    end else begin
      for (int t = 0; t < TRIPLES; t++) pat_mem[n_used][t] = gather[t];
      cnt_mem[n_used] = 32'd1;
      fill_report(r, n_used, w.element_sel);
      n_used++;
    end
    result_q = {result_q, r};
  endtask

  // driver
  initial begin
    in_ch.valid = 1'b0;
    {in_ch.action, in_ch.pix_first, in_ch.pix_middle, in_ch.pix_last,
     in_ch.entry_sel, in_ch.element_sel} = '0;
  end

  always @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      predict_word({in_ch.action, in_ch.pix_first, in_ch.pix_middle, in_ch.pix_last,
                    in_ch.entry_sel, in_ch.element_sel});
      n_words++;
    end
    if ((!in_ch.valid || in_ch.ready) && rst_ni) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_word_t w;
        w = pending_q.pop_front();
        in_ch.valid <= 1'b1;
        {in_ch.action, in_ch.pix_first, in_ch.pix_middle, in_ch.pix_last,
         in_ch.entry_sel, in_ch.element_sel} <= w;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  initial out_ch.ready = 1'b0;

  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      out_word_t got, want;
      got = {out_ch.is_readout, out_ch.hit, out_ch.dropped, out_ch.entry_index,
             out_ch.count, out_ch.entry_valid, out_ch.qualifies, out_ch.element_value};
      n_results++;
      if (got.hit) n_hits++;
      if (got.dropped) n_drops++;
      if (got.is_readout) n_reads++;
      if (result_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected word: %p", got);
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          n_err++;
          if (n_err <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
    out_ch.ready <= rst_ni && !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [31:0] d);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == ADDR_MIN_COUNT) thresh = d[15:0];
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_ch.valid || result_q.size() > 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
  endtask

  function automatic in_word_t push_word(logic [23:0] t, logic [4:0] k);
    in_word_t w;
    w = '0;
    {w.pix_first, w.pix_middle, w.pix_last} = t;
    w.element_sel = k;
    return w;
  endfunction

  function automatic in_word_t read_word(logic [7:0] e, logic [4:0] k);
    in_word_t w;
    w = '0;
    w.action = 1'b1;
    w.entry_sel = e;
    w.element_sel = k;
    w.pix_first = 8'($urandom);
    return w;
  endfunction

  // a pattern from a small pool so that hits are frequent
  task automatic queue_pattern(input int seed_id, input bit flat);
    for (int t = 0; t < TRIPLES; t++)
      pending_q = {pending_q, push_word(flat ? {3{seed_id[7:0]}} :
                                        24'(seed_id * 7919 + t * 40503),
                                        5'($urandom_range(31)))};
  endtask

  task automatic queue_random(input int n, input int pool);
    int i;
    i = 0;
    while (i < n) begin
      int r;
      r = $urandom_range(99);
      if (r < 70) begin
        queue_pattern($urandom_range(pool), $urandom_range(9) == 0);
        if ($urandom_range(3) == 0) pending_q.insert(pending_q.size() - 4,
                                      read_word(8'($urandom), 5'($urandom_range(31))));
        i += 9;
      end else if (r < 90) begin
        pending_q = {pending_q, read_word(8'($urandom_range(n_used + 4)),
                                          5'($urandom_range(31)))};
        i++;
      end else begin
        in_word_t w;
        w = in_word_t'(38'($urandom));
        pending_q = {pending_q, w};
        i++;
      end
    end
  endtask

  initial begin
    n_used = 0; gather_pos = 0; thresh = MIN_COUNT_RESET;
    n_err = 0; n_words = 0; n_results = 0; n_hits = 0; n_drops = 0; n_reads = 0;
    send_idle_pct = 11; recv_idle_pct = 81; hold_off = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset threshold, extremes, flat pattern, readouts, partial pattern
    pending_q = {pending_q, read_word(8'd0, 5'd0)};
    for (int t = 0; t < TRIPLES; t++) pending_q = {pending_q, push_word(24'h000000, 5'd0)};
    for (int t = 0; t < TRIPLES; t++) begin
      pending_q = {pending_q, push_word(24'hFFFFFF, 5'd26)};
      if (t == 4) pending_q = {pending_q, read_word(8'd0, 5'd31)};
    end
    for (int t = 0; t < TRIPLES; t++) pending_q = {pending_q, push_word(24'h000000, 5'd27)};
    pending_q = {pending_q, read_word(8'd1, 5'd26)};
    pending_q = {pending_q, read_word(8'd255, 5'd5)};
    wait_drained();

    apb_write(ADDR_MIN_COUNT, 32'd0);
    queue_random(300, 12);
    wait_drained();

    // long receiver stall while the sender keeps offering
    apb_write(ADDR_MIN_COUNT, 32'd3);
    send_idle_pct = 81; recv_idle_pct = 11;
    queue_random(350, 40);
    hold_off = 1'b1;
    repeat (3000) @(posedge clk_i);
    hold_off = 1'b0;
    wait_drained();

    // fill the table to force drops
    apb_write(ADDR_MIN_COUNT, 32'hFFFF);
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int p = 0; p < TABLE_ENTRIES + 8; p++) queue_pattern(1000 + p, 1'b0);
    queue_random(350, 60);
    wait_drained();

    apb_write(ADDR_MIN_COUNT, 32'd1);
    queue_random(60, 20);
    for (int e = 0; e < 8; e++)
      pending_q = {pending_q, read_word(8'(e), 5'($urandom_range(26)))};
    wait_drained();

    $display("%0d words sent, %0d results: %0d hits, %0d drops, %0d readouts, %0d entries",
             n_words, n_results, n_hits, n_drops, n_reads, n_used);
    if (n_err == 0 && result_q.size() == 0) $display("** voxel_pattern_counter_top: PASSED **");
    else begin
      $display("%0d mismatches, %0d results missing", n_err, result_q.size());
      $display("** voxel_pattern_counter_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #80ms;
    $display("timeout");
    $display("** voxel_pattern_counter_top: FAILED **");
    $finish;
  end

endmodule

// ===== voxel_pattern_counter_top.f =====
rtl/vpc_pkg.sv
rtl/vpc_if.sv
rtl/vpc_ram.sv
rtl/vpc_ctrl.sv
rtl/vpc_datapath.sv
rtl/voxel_pattern_counter_top.sv
rtl/vpc_checker.sv
tb/voxel_pattern_counter_top_tb.sv
